// ----- hw/rtl/eus_pkg.sv -----
// eus_pkg: shared types and constants of the edge uniform subdivider
// no dependencies; used by eus_iter_unit and edge_uniform_subdivider
package eus_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TagW   = 24;
  localparam int unsigned FieldIdxW = 24;
  localparam int unsigned TargetW = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned UnitW  = 40;

  localparam logic [CfgIdxW-1:0] CfgTarget = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBase   = 2'd1;

  localparam logic [TargetW-1:0] TargetReset = 31'd65536;

  typedef enum logic {
    OpMul,
    OpDiv
  } eus_op_e;

  typedef struct packed {
    logic    start;
    eus_op_e op;
  } eus_cmd_t;

endpackage

// ----- hw/rtl/eus_iter_unit.sv -----
// eus_iter_unit: shared radix-2 shift-add multiplier and restoring divider
// depends on eus_pkg (UnitW, eus_cmd_t)
module eus_iter_unit import eus_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eus_cmd_t           cmd_i,
  input  logic [UnitW-1:0]   opa_i,
  input  logic [UnitW-1:0]   opb_i,
  output logic               done_o,
  output logic [2*UnitW-1:0] res_o
);

  localparam int unsigned CntW = $clog2(UnitW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  eus_op_e         op_q;
  logic [UnitW-1:0] b_q, hi_q, lo_q;
  logic [UnitW:0]  sum, rsh, rsub;
  logic            ge;

  // multiply: add multiplicand on lsb then shift right
  assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);
  // divide: shift remainder left, subtract when it fits
  assign rsh  = {hi_q, lo_q[UnitW-1]};
  assign ge   = (rsh >= {1'b0, b_q});
  assign rsub = rsh - {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OpMul;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        op_q   <= cmd_i.op;
        b_q    <= (cmd_i.op == OpMul) ? opa_i : opb_i;
        hi_q   <= '0;
        lo_q   <= (cmd_i.op == OpMul) ? opb_i : opa_i;
      end else if (busy_q) begin
        if (op_q == OpMul) begin
          hi_q <= sum[UnitW:1];
          lo_q <= {sum[0], lo_q[UnitW-1:1]};
        end else begin
          hi_q <= ge ? rsub[UnitW-1:0] : rsh[UnitW-1:0];
          lo_q <= {lo_q[UnitW-2:0], ge};
        end
        if (cnt_q == CntW'(UnitW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OpMul) ? {hi_q, lo_q} : {{UnitW{1'b0}}, lo_q};

endmodule

// ----- hw/rtl/edge_uniform_subdivider.sv -----
// edge_uniform_subdivider: splits one 3-d edge per item into n equal sub-segments
// sequence: four multiplies and a count walk over n, then per new vertex
//   three divisions, a segment step and a load; the last result takes a segment step and a load
// flow: one edge at a time, with loads held while the output stalls (a zero-length edge
//   gives no output); next edge taken once its last result is loaded
// reset: async active low; target length 1.0, vertex base 0, vertex counter 0
module edge_uniform_subdivider import eus_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned INDEX_BITS   = FieldIdxW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  // edge items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [TagW-1:0]            edge_tag_i,
  input  logic [INDEX_BITS-1:0]      start_index_i,
  input  logic [INDEX_BITS-1:0]      end_index_i,
  input  logic signed [CoordW-1:0]   start_x_i,
  input  logic signed [CoordW-1:0]   start_y_i,
  input  logic signed [CoordW-1:0]   start_z_i,
  input  logic signed [CoordW-1:0]   end_x_i,
  input  logic signed [CoordW-1:0]   end_y_i,
  input  logic signed [CoordW-1:0]   end_z_i,
  // sub-segment items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [INDEX_BITS-1:0]      seg_from_index_o,
  output logic [INDEX_BITS-1:0]      seg_to_index_o,
  output logic                       has_new_vertex_o,
  output logic signed [CoordW-1:0]   vertex_x_o,
  output logic signed [CoordW-1:0]   vertex_y_o,
  output logic signed [CoordW-1:0]   vertex_z_o,
  output logic [TagW-1:0]            source_edge_o,
  output logic                       count_clamped_o,
  output logic                       last_o
);

  localparam int unsigned NW    = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned MagW  = CoordW + 1;     // |end - start| below 2^32
  localparam int unsigned Len2W = 2 * MagW + 1;   // sum of three squares
  localparam int unsigned T2W   = 2 * TargetW;
  localparam int unsigned SqW   = T2W + 2 * NW + 2;
  localparam int unsigned PW    = UnitW - 1;      // k*|d| for k below the count
  localparam int unsigned QW    = MagW;
  localparam logic [INDEX_BITS-1:0] IdxMask = '1;

  typedef enum logic [3:0] {
    StIdle, StSqStart, StSqWait, StTtStart, StTtWait,
    StCount, StSeg, StVxStart, StVxWait, StLoad
  } state_e;

  state_e st_q;
  eus_cmd_t cmd_q;

  logic [TargetW-1:0]    target_q;
  logic [INDEX_BITS-1:0] base_q, vcnt_q;

  logic [TagW-1:0]       tag_q;
  logic [INDEX_BITS-1:0] end_idx_q, cur_q;
  logic signed [CoordW-1:0] s_q [3];
  logic [MagW-1:0]       m_q [3];
  logic                  neg_q [3];
  logic [PW-1:0]         p_q [3];
  logic [CoordW-1:0]     vx_q [3];
  logic [1:0]            j_q;
  logic [NW-1:0]         n_q, i_q;
  logic                  clamp_q;
  logic [Len2W-1:0]      len2_q;
  logic [T2W-1:0]        t2_q;
  logic [SqW-1:0]        sq_q, incr_q;

  // unit interface
  logic [UnitW-1:0]   opa, opb;
  logic               u_done;
  logic [2*UnitW-1:0] u_res;

  // output register
  logic                  ov_q, hv_q, cl_q, lt_q;
  logic [INDEX_BITS-1:0] of_q, ot_q;
  logic [CoordW-1:0]     ox_q, oy_q, oz_q;
  logic [TagW-1:0]       os_q;

  // input differences, taken as sign and magnitude
  logic signed [MagW-1:0] din [3];
  logic [MagW-1:0]        dmag [3];
  assign din[0] = MagW'(end_x_i) - MagW'(start_x_i);
  assign din[1] = MagW'(end_y_i) - MagW'(start_y_i);
  assign din[2] = MagW'(end_z_i) - MagW'(start_z_i);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dmag[k] = din[k][MagW-1] ? MagW'(-din[k]) : MagW'(din[k]);
    end
  end

  // operands follow the wait state, in which the registered start reaches the unit
  always_comb begin
    opa = '0;
    opb = '0;
    case (st_q)
      StSqWait: begin
        opa = UnitW'(m_q[j_q]);
        opb = UnitW'(m_q[j_q]);
      end
      StTtWait: begin
        opa = UnitW'(target_q);
        opb = UnitW'(target_q);
      end
      StVxWait: begin
        // round to nearest, ties away from zero: (2m + n) / 2n
        opa = UnitW'({p_q[j_q], 1'b0}) + UnitW'(n_q);
        opb = UnitW'({n_q, 1'b0});
      end
      default: ;
    endcase
  end

  eus_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_q),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (u_done),
    .res_o  (u_res)
  );

  // next values used by several branches
  logic [Len2W-1:0] len2_d;
  logic [QW-1:0]    quot;
  logic [MagW:0]    off, vsum;
  logic             is_last, out_free;
  logic [INDEX_BITS-1:0] new_idx;

  assign len2_d  = len2_q + Len2W'(u_res[2*MagW-1:0]);
  assign quot    = u_res[QW-1:0];
  assign off     = neg_q[j_q] ? (MagW+1)'(0) - {1'b0, quot} : {1'b0, quot};
  assign vsum    = {{2{s_q[j_q][CoordW-1]}}, s_q[j_q]} + off;
  assign is_last = (NW'(i_q + 1'b1) == n_q);
  assign out_free = !ov_q || !out_stall_i;
  assign new_idx = (base_q + vcnt_q) & IdxMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      cmd_q    <= '{start: 1'b0, op: OpMul};
      target_q <= TargetReset;
      base_q   <= '0;
      vcnt_q   <= '0;
      ov_q     <= 1'b0;
      j_q      <= '0;
      n_q      <= '0;
      i_q      <= '0;
    end else begin
      // start pulse for one cycle, on leaving a start state
      cmd_q.start <= st_q inside {StSqStart, StTtStart, StVxStart};

      // the user must make register writes only while idle; the block does not enforce it
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgTarget: target_q <= cfg_data_i[TargetW-1:0];
          CfgBase:   base_q   <= cfg_data_i[INDEX_BITS-1:0] & IdxMask;
          default: ;
        endcase
      end

      // the load state refills the output register itself
      if (ov_q && !out_stall_i && st_q != StLoad) ov_q <= 1'b0;

      case (st_q)
        StIdle: begin
          if (in_valid_i) begin
            tag_q     <= edge_tag_i;
            cur_q     <= start_index_i & IdxMask;
            end_idx_q <= end_index_i & IdxMask;
            s_q[0] <= start_x_i;
            s_q[1] <= start_y_i;
            s_q[2] <= start_z_i;
            for (int k = 0; k < 3; k++) begin
              m_q[k]   <= dmag[k];
              neg_q[k] <= din[k][MagW-1];
            end
            len2_q <= '0;
            j_q    <= '0;
            st_q   <= StSqStart;
          end
        end
        StSqStart: begin
          cmd_q.op <= OpMul;
          st_q     <= StSqWait;
        end
        StSqWait: begin
          if (u_done) begin
            len2_q <= len2_d;
            if (j_q == 2'd2) begin
              // zero-length edge gives nothing
              st_q <= (len2_d == '0) ? StIdle : StTtStart;
            end else begin
              j_q  <= j_q + 1'b1;
              st_q <= StSqStart;
            end
          end
        end
        StTtStart: begin
          cmd_q.op <= OpMul;
          st_q     <= StTtWait;
        end
        StTtWait: begin
          if (u_done) begin
            t2_q   <= u_res[T2W-1:0];
            sq_q   <= SqW'(u_res[T2W-1:0]);
            incr_q <= SqW'(u_res[T2W-1:0]) + SqW'({u_res[T2W-1:0], 1'b0});
            n_q    <= NW'(1);
            st_q   <= StCount;
          end
        end
        StCount: begin
          // walk n upward: (n*T)^2 grows by (2n+1)*T^2 per step
          if (sq_q >= SqW'(len2_q) || n_q == NW'(MAX_SEGMENTS)) begin
            clamp_q <= !(sq_q >= SqW'(len2_q));
            i_q     <= '0;
            for (int k = 0; k < 3; k++) p_q[k] <= PW'(m_q[k]);
            st_q    <= StSeg;
          end else begin
            sq_q   <= sq_q + incr_q;
            incr_q <= incr_q + SqW'({t2_q, 1'b0});
            n_q    <= n_q + 1'b1;
          end
        end
        StSeg: begin
          j_q  <= '0;
          st_q <= is_last ? StLoad : StVxStart;
        end
        StVxStart: begin
          cmd_q.op <= OpDiv;
          st_q     <= StVxWait;
        end
        StVxWait: begin
          if (u_done) begin
            vx_q[j_q] <= vsum[CoordW-1:0];
            if (j_q == 2'd2) st_q <= StLoad;
            else begin
              j_q  <= j_q + 1'b1;
              st_q <= StVxStart;
            end
          end
        end
        StLoad: begin
          if (out_free) begin
            ov_q <= 1'b1;
            of_q <= cur_q;
            os_q <= tag_q;
            cl_q <= clamp_q;
            lt_q <= is_last;
            hv_q <= !is_last;
            if (is_last) begin
              ot_q <= end_idx_q;
              ox_q <= '0;
              oy_q <= '0;
              oz_q <= '0;
              st_q <= StIdle;
            end else begin
              ot_q   <= new_idx;
              ox_q   <= vx_q[0];
              oy_q   <= vx_q[1];
              oz_q   <= vx_q[2];
              cur_q  <= new_idx;
              vcnt_q <= vcnt_q + 1'b1;
              i_q    <= i_q + 1'b1;
              for (int k = 0; k < 3; k++) p_q[k] <= p_q[k] + PW'(m_q[k]);
              st_q   <= StSeg;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign in_stall_o       = (st_q != StIdle);
  assign out_valid_o      = ov_q;
  assign seg_from_index_o = of_q;
  assign seg_to_index_o   = ot_q;
  assign has_new_vertex_o = hv_q;
  assign vertex_x_o       = ox_q;
  assign vertex_y_o       = oy_q;
  assign vertex_z_o       = oz_q;
  assign source_edge_o    = os_q;
  assign count_clamped_o  = cl_q;
  assign last_o           = lt_q;

`ifndef SYNTHESIS
  // an accepted edge keeps the input side busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting an edge");

  // the final sub-segment never carries a new vertex
  a_last_no_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(has_new_vertex_o && last_o))
    else $error("last sub-segment flagged with a new vertex");

  // the shared unit only finishes while a wait state expects it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> (st_q == StSqWait || st_q == StTtWait || st_q == StVxWait))
    else $error("arithmetic unit finished outside a wait state");
`endif

endmodule
